@@ design/eth_ipv4_l4_header_extractor_macros.svh @@
// assertion macros used by the header extractor port checker
`ifndef ETH_IPV4_L4_HEADER_EXTRACTOR_MACROS_SVH
`define ETH_IPV4_L4_HEADER_EXTRACTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define EIL4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define EIL4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/eil4_pkg.sv @@
// types and constants for the ethernet/ipv4/l4 header extractor
`timescale 1ns / 1ps

package eil4_pkg;

    // one request on the input side
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_item;

    // one request on the output side
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] eth_type;
        logic [7:0]  time_to_live;
        logic [7:0]  ip_protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [1:0]  transport_kind;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] frame_length;
        logic        truncated;
    } t_out_item;

    // transport kind codes
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_TCP     = 2'd1;
    localparam logic [1:0] KIND_UDP     = 2'd2;

    // ip protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // byte offsets within the frame
    localparam logic [15:0] POS_SRC_MAC = 16'd6;
    localparam logic [15:0] POS_TYPE    = 16'd12;
    localparam logic [15:0] POS_IP_HDR  = 16'd14;
    localparam logic [15:0] POS_TTL     = 16'd22;
    localparam logic [15:0] POS_PROTO   = 16'd23;
    localparam logic [15:0] POS_SRC_IP  = 16'd26;
    localparam logic [15:0] POS_DST_IP  = 16'd30;
    localparam logic [15:0] POS_IP_END  = 16'd34;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;

    // port window base is eth header length plus 4 * ihl, at most 74
    localparam logic [6:0] ETH_HDR_LEN = 7'd14;
    localparam logic [6:0] IP_ADDR_END = 7'd34;
    localparam logic [6:0] PORT_BYTES  = 7'd4;
    localparam logic [3:0] IHL_MASK    = 4'hF;

endpackage

@@ design/eil4_capture.sv @@
// per-frame field capture state and result formation
`timescale 1ns / 1ps

module eil4_capture
    import eil4_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [15:0] r_byte_position;
    logic [3:0]  r_header_words;
    logic [47:0] r_dst_mac;
    logic [47:0] r_src_mac;
    logic [15:0] r_type;
    logic [7:0]  r_ttl;
    logic [7:0]  r_protocol;
    logic [31:0] r_src_ip;
    logic [31:0] r_dst_ip;
    logic [15:0] r_src_port;
    logic [15:0] r_dst_port;

    logic [15:0] n_byte_position;
    logic [3:0]  n_header_words;
    logic [47:0] n_dst_mac;
    logic [47:0] n_src_mac;
    logic [15:0] n_type;
    logic [7:0]  n_ttl;
    logic [7:0]  n_protocol;
    logic [31:0] n_src_ip;
    logic [31:0] n_dst_ip;
    logic [15:0] n_src_port;
    logic [15:0] n_dst_port;

    logic [7:0]  b;
    logic [15:0] p;
    logic [3:0]  ihl;
    logic [6:0]  base;
    logic [15:0] port_off;
    logic        in_window;
    logic [6:0]  need;
    logic [1:0]  kind;

    assign b = i_item.frame_byte;
    assign p = r_byte_position;

    // ihl comes from the current byte when it is the first ip header byte
    assign ihl       = (p == POS_IP_HDR) ? (b[3:0] & IHL_MASK) : r_header_words;
    assign base      = ETH_HDR_LEN + {1'b0, ihl, 2'b00};
    assign in_window = (p >= {9'd0, base});
    assign port_off  = p - {9'd0, base};

    // fixed header fields shift in big-endian
    always_comb begin
        n_dst_mac = r_dst_mac;
        n_src_mac = r_src_mac;
        n_type    = r_type;
        n_ttl     = r_ttl;
        n_protocol = r_protocol;
        n_src_ip  = r_src_ip;
        n_dst_ip  = r_dst_ip;
        if (p < POS_SRC_MAC) begin
            n_dst_mac = {r_dst_mac[39:0], b};
        end else if (p < POS_TYPE) begin
            n_src_mac = {r_src_mac[39:0], b};
        end else if (p < POS_IP_HDR) begin
            n_type = {r_type[7:0], b};
        end else if (p == POS_TTL) begin
            n_ttl = b;
        end else if (p == POS_PROTO) begin
            n_protocol = b;
        end else if (p >= POS_SRC_IP && p < POS_DST_IP) begin
            n_src_ip = {r_src_ip[23:0], b};
        end else if (p >= POS_DST_IP && p < POS_IP_END) begin
            n_dst_ip = {r_dst_ip[23:0], b};
        end
    end

    // ihl and port window capture
    always_comb begin
        n_header_words = (p == POS_IP_HDR) ? ihl : r_header_words;
        n_src_port     = r_src_port;
        n_dst_port     = r_dst_port;
        if (in_window && port_off < 16'd2) begin
            n_src_port = {r_src_port[7:0], b};
        end else if (in_window && port_off < 16'd4) begin
            n_dst_port = {r_dst_port[7:0], b};
        end
    end

    // byte counter saturates, and doubles as the frame length
    assign n_byte_position = (p != POS_MAX) ? p + 16'd1 : p;

    // transport kind and minimum length
    always_comb begin
        if (n_protocol == PROTO_TCP) begin
            kind = KIND_TCP;
        end else if (n_protocol == PROTO_UDP) begin
            kind = KIND_UDP;
        end else begin
            kind = KIND_UNKNOWN;
        end
        need = IP_ADDR_END;
        if (kind != KIND_UNKNOWN && (base + PORT_BYTES) > IP_ADDR_END) begin
            need = base + PORT_BYTES;
        end
    end

    // result as seen after this byte
    always_comb begin
        o_result.dst_mac        = n_dst_mac;
        o_result.src_mac        = n_src_mac;
        o_result.eth_type       = n_type;
        o_result.time_to_live   = n_ttl;
        o_result.ip_protocol    = n_protocol;
        o_result.src_ip         = n_src_ip;
        o_result.dst_ip         = n_dst_ip;
        o_result.transport_kind = kind;
        o_result.src_port       = (kind != KIND_UNKNOWN) ? n_src_port : 16'd0;
        o_result.dst_port       = (kind != KIND_UNKNOWN) ? n_dst_port : 16'd0;
        o_result.frame_length   = n_byte_position;
        o_result.truncated      = (n_byte_position < {9'd0, need});
    end

    // state update, cleared after the last byte of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_byte_position <= '0;
            r_header_words  <= '0;
            r_dst_mac       <= '0;
            r_src_mac       <= '0;
            r_type          <= '0;
            r_ttl           <= '0;
            r_protocol      <= '0;
            r_src_ip        <= '0;
            r_dst_ip        <= '0;
            r_src_port      <= '0;
            r_dst_port      <= '0;
        end else if (i_step) begin
            r_byte_position <= n_byte_position;
            r_header_words  <= n_header_words;
            r_dst_mac       <= n_dst_mac;
            r_src_mac       <= n_src_mac;
            r_type          <= n_type;
            r_ttl           <= n_ttl;
            r_protocol      <= n_protocol;
            r_src_ip        <= n_src_ip;
            r_dst_ip        <= n_dst_ip;
            r_src_port      <= n_src_port;
            r_dst_port      <= n_dst_port;
        end
    end

endmodule

@@ design/eth_ipv4_l4_header_extractor.sv @@
// top level of the ethernet/ipv4/l4 header extractor
// a final byte passes the input register, then the result register, before its result is offered
// throughput: one byte per cycle, except while a final byte waits for the result register
// a final byte waits in the input register only while the result register is full and stalled
// reset (synchronous, active low) clears the valid flags of both registers and all frame capture state
`timescale 1ns / 1ps

module eth_ipv4_l4_header_extractor
    import eil4_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free;
    logic      step;
    logic      in_acc;
    t_out_item result;

    // a byte advances unless it ends a frame and the result slot is busy
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && (!r_in_item.last_byte || out_free);
    assign o_in_stall = r_in_valid && !step;
    assign in_acc     = i_in_valid && !o_in_stall;

    eil4_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_item.last_byte) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ design/eil4_checker.sv @@
// port-level assertions for the header extractor, bound to the top level
`timescale 1ns / 1ps
`include "eth_ipv4_l4_header_extractor_macros.svh"

module eil4_checker
    import eil4_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result stays offered
    `EIL4_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // a stalled result does not change
    `EIL4_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_item), "result changed while stalled")

    // a new result follows an accepted final byte
    `EIL4_ASSERT_NOW(a_out_source, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && !o_in_stall && i_in_item.last_byte, 2), "result without a final byte")

    // frames shorter than the ip address fields are flagged
    `EIL4_ASSERT_NOW(a_short_flag, i_clk, i_rst_n, o_out_valid && (o_out_item.frame_length < POS_IP_END), o_out_item.truncated, "short frame not flagged")

endmodule

bind eth_ipv4_l4_header_extractor eil4_checker u_eil4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ tb/eil4_header_checker.sv @@
// checker for the header extractor: predicts each frame header and compares it field by field
`timescale 1ns / 1ps

module eil4_header_checker
    import eil4_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_mismatch_count,
    output int        o_pending,
    output int        o_checked
);

    // header fields gathered from the frame in progress
    logic [15:0] byte_pos;
    logic [3:0]  ihl_seen;
    logic [47:0] dst_mac_acc;
    logic [47:0] src_mac_acc;
    logic [15:0] type_acc;
    logic [7:0]  ttl_acc;
    logic [7:0]  proto_acc;
    logic [31:0] src_ip_acc;
    logic [31:0] dst_ip_acc;
    logic [15:0] src_port_acc;
    logic [15:0] dst_port_acc;

    // predicted headers, oldest first
    t_out_item expected_headers[$];

    task automatic clear_capture();
        byte_pos     = '0;
        ihl_seen     = '0;
        dst_mac_acc  = '0;
        src_mac_acc  = '0;
        type_acc     = '0;
        ttl_acc      = '0;
        proto_acc    = '0;
        src_ip_acc   = '0;
        dst_ip_acc   = '0;
        src_port_acc = '0;
        dst_port_acc = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("header %0d: %s is %0h, predicted %0h", o_checked, what, got, want);
        o_mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // fold one accepted byte into the header; a last byte yields a prediction
    task automatic capture_byte(input t_in_item req);
        int          p;
        int          port_base;
        int          len_now;
        int          need;
        logic [3:0]  ihl;
        logic [7:0]  b;
        t_out_item   hdr;

        b = req.frame_byte;
        p = int'(byte_pos);
        ihl = (byte_pos == POS_IP_HDR) ? (b[3:0] & IHL_MASK) : ihl_seen;
        port_base = int'(ETH_HDR_LEN) + 4 * int'(ihl);

        // fixed-offset fields
        if (byte_pos < POS_SRC_MAC) begin
            dst_mac_acc = {dst_mac_acc[39:0], b};
        end else if (byte_pos < POS_TYPE) begin
            src_mac_acc = {src_mac_acc[39:0], b};
        end else if (byte_pos < POS_IP_HDR) begin
            type_acc = {type_acc[7:0], b};
        end else if (byte_pos == POS_TTL) begin
            ttl_acc = b;
        end else if (byte_pos == POS_PROTO) begin
            proto_acc = b;
        end else if (byte_pos >= POS_SRC_IP && byte_pos < POS_DST_IP) begin
            src_ip_acc = {src_ip_acc[23:0], b};
        end else if (byte_pos >= POS_DST_IP && byte_pos < POS_IP_END) begin
            dst_ip_acc = {dst_ip_acc[23:0], b};
        end

        if (byte_pos == POS_IP_HDR) begin
            ihl_seen = b[3:0] & IHL_MASK;
        end

        // port window moves with the ihl
        if (p >= port_base && p < port_base + 2) begin
            src_port_acc = {src_port_acc[7:0], b};
        end else if (p >= port_base + 2 && p < port_base + 4) begin
            dst_port_acc = {dst_port_acc[7:0], b};
        end

        len_now = (byte_pos < POS_MAX) ? p + 1 : int'(POS_MAX);
        if (byte_pos < POS_MAX) begin
            byte_pos = byte_pos + 16'd1;
        end

        if (req.last_byte) begin
            hdr.dst_mac      = dst_mac_acc;
            hdr.src_mac      = src_mac_acc;
            hdr.eth_type     = type_acc;
            hdr.time_to_live = ttl_acc;
            hdr.ip_protocol  = proto_acc;
            hdr.src_ip       = src_ip_acc;
            hdr.dst_ip       = dst_ip_acc;
            if (proto_acc == PROTO_TCP) begin
                hdr.transport_kind = KIND_TCP;
            end else if (proto_acc == PROTO_UDP) begin
                hdr.transport_kind = KIND_UDP;
            end else begin
                hdr.transport_kind = KIND_UNKNOWN;
            end
            need = int'(IP_ADDR_END);
            if (hdr.transport_kind != KIND_UNKNOWN
                && port_base + int'(PORT_BYTES) > need) begin
                need = port_base + int'(PORT_BYTES);
            end
            hdr.src_port = (hdr.transport_kind != KIND_UNKNOWN) ? src_port_acc : 16'd0;
            hdr.dst_port = (hdr.transport_kind != KIND_UNKNOWN) ? dst_port_acc : 16'd0;
            hdr.frame_length = len_now[15:0];
            hdr.truncated    = (len_now < need);
            expected_headers.push_back(hdr);
            clear_capture();
        end
    endtask

    task automatic check_header(input t_out_item got);
        t_out_item want;
        if (expected_headers.size() == 0) begin
            report_mismatch("result with no frame pending", 64'd1, 64'd0);
            return;
        end
        want = expected_headers.pop_front();
        check_field("dst_mac", got.dst_mac, want.dst_mac);
        check_field("src_mac", got.src_mac, want.src_mac);
        check_field("eth_type", got.eth_type, want.eth_type);
        check_field("time_to_live", got.time_to_live, want.time_to_live);
        check_field("ip_protocol", got.ip_protocol, want.ip_protocol);
        check_field("src_ip", got.src_ip, want.src_ip);
        check_field("dst_ip", got.dst_ip, want.dst_ip);
        check_field("transport_kind", got.transport_kind, want.transport_kind);
        check_field("src_port", got.src_port, want.src_port);
        check_field("dst_port", got.dst_port, want.dst_port);
        check_field("frame_length", got.frame_length, want.frame_length);
        check_field("truncated", got.truncated, want.truncated);
        o_checked++;
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_capture();
            expected_headers.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                capture_byte(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                check_header(i_out_item);
            end
        end
        o_pending = expected_headers.size();
    end

endmodule

@@ tb/tb_eth_ipv4_l4_header_extractor.sv @@
// testbench top for the header extractor: frame stimulus, random stalls and the verdict
`timescale 1ns / 1ps

module tb_eth_ipv4_l4_header_extractor;
    import eil4_pkg::*;

    localparam int RANDOM_BYTES      = 1380;
    localparam int MIN_RANDOM_FRAMES = 20;
    localparam int CYCLE_LIMIT       = 600000;
    localparam int DRAIN_CYCLES      = 20;
    localparam int RANDOM_FILL       = -1;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    int mismatches;
    int pending;
    int checked;
    int cycle_count = 0;
    int frames_sent = 0;
    int bytes_sent  = 0;

    // bytes of the frame about to be sent
    logic [7:0] frame_bytes[$];

    always #1 clk = ~clk;

    eth_ipv4_l4_header_extractor uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    eil4_header_checker header_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (out_item),
        .o_mismatch_count(mismatches),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    // fill a frame, forcing the ihl nibble and the protocol byte where they fall
    task automatic build_frame(input logic [3:0] ihl, input logic [7:0] proto,
                               input int len, input int fill);
        logic [7:0] b;
        frame_bytes.delete();
        for (int k = 0; k < len; k++) begin
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            if (k == int'(POS_IP_HDR)) begin
                b = {b[7:4], ihl};
            end
            if (k == int'(POS_PROTO)) begin
                b = proto;
            end
            frame_bytes.push_back(b);
        end
    endtask

    // one request per byte, last_byte on the final one
    task automatic send_frame(input bit no_gaps);
        int       gap;
        t_in_item req;
        for (int k = 0; k < frame_bytes.size(); k++) begin
            gap = no_gaps ? 0 : pick_gap();
            repeat (gap) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            req.frame_byte = frame_bytes[k];
            req.last_byte  = (k == frame_bytes.size() - 1);
            in_valid <= 1'b1;
            in_item  <= req;
            do @(posedge clk); while (in_stall);
            @(negedge clk);
        end
        frames_sent++;
        bytes_sent += frame_bytes.size();
    endtask

    // receiver stalls: bursts of stall, stretches without
    initial begin
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever begin
            n = pick_gap();
            repeat (n) begin
                out_stall <= 1'b1;
                @(negedge clk);
            end
            n = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 80) : $urandom_range(1, 6);
            repeat (n) begin
                out_stall <= 1'b0;
                @(negedge clk);
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int         r;
        int         ihl;
        int         len;
        int         need;
        int         sel;
        int         random_bytes;
        int         random_frames;
        logic [7:0] proto;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames: extremes, every transport kind, short and odd-ihl frames
        build_frame(4'd5, PROTO_TCP, 60, 8'h00);
        send_frame(1'b0);
        build_frame(4'd15, PROTO_UDP, 78, 8'hFF);
        send_frame(1'b0);
        build_frame(4'd5, PROTO_TCP, 38, RANDOM_FILL);
        send_frame(1'b0);
        build_frame(4'd5, PROTO_TCP, 37, RANDOM_FILL);
        send_frame(1'b0);
        build_frame(4'd0, PROTO_UDP, 34, RANDOM_FILL);
        send_frame(1'b1);
        build_frame(4'd3, PROTO_TCP, 40, RANDOM_FILL);
        send_frame(1'b0);
        build_frame(4'd5, 8'd1, 34, RANDOM_FILL);
        send_frame(1'b0);
        build_frame(4'd5, 8'd1, 33, RANDOM_FILL);
        send_frame(1'b0);
        build_frame(4'd5, PROTO_TCP, 1, RANDOM_FILL);
        send_frame(1'b1);
        build_frame(4'd5, PROTO_UDP, 1, 8'hFF);
        send_frame(1'b1);
        build_frame(4'd5, PROTO_UDP, 14, RANDOM_FILL);
        send_frame(1'b0);
        build_frame(4'd5, PROTO_UDP, 24, RANDOM_FILL);
        send_frame(1'b0);
        build_frame(4'd15, PROTO_TCP, 77, RANDOM_FILL);
        send_frame(1'b0);

        // random frames: mostly well formed, the rest short or noise
        random_bytes  = 0;
        random_frames = 0;
        while (random_bytes < RANDOM_BYTES || random_frames < MIN_RANDOM_FRAMES) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
                sel = $urandom_range(0, 4);
                if (sel < 2) begin
                    proto = PROTO_TCP;
                end else if (sel < 4) begin
                    proto = PROTO_UDP;
                end else begin
                    proto = 8'($urandom_range(0, 255));
                end
                need = int'(ETH_HDR_LEN) + 4 * ihl + int'(PORT_BYTES);
                if (need < int'(IP_ADDR_END)) begin
                    need = int'(IP_ADDR_END);
                end
                len = need - 1 + $urandom_range(0, 12);
            end else begin
                ihl   = $urandom_range(0, 15);
                proto = 8'($urandom_range(0, 255));
                len   = $urandom_range(1, 40);
            end
            build_frame(ihl[3:0], proto, len, RANDOM_FILL);
            if (r < 35 && len > int'(POS_IP_HDR)) begin
                frame_bytes[12] = 8'h08;
                frame_bytes[13] = 8'h00;
            end
            send_frame($urandom_range(0, 3) == 0);
            random_bytes += len;
            random_frames++;
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d frames (%0d bytes): short, truncated, odd-IHL, TCP/UDP/other",
                 frames_sent, bytes_sent);
        $display("compared %0d headers, %0d field mismatches", checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/eil4_pkg.sv
design/eil4_capture.sv
design/eth_ipv4_l4_header_extractor.sv
design/eil4_checker.sv
tb/eil4_header_checker.sv
tb/tb_eth_ipv4_l4_header_extractor.sv
